FILE: src/tmt_pkg.sv
// Shared types, constants and the day-rule check for the timed event match table.
`default_nettype none

package tmt_pkg;

	localparam int EVENT_SLOTS = 64;
	localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

	localparam int LIGHT_W  = 8;
	localparam int RULE_W   = 4;
	localparam int MINUTE_W = 11;
	localparam int DAY_W    = 3;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_SCHED_ON  = 2'd0;
	localparam logic [OP_W-1:0] OP_SCHED_OFF = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

	localparam logic [RULE_W-1:0] RULE_EVERY_DAY = 4'd7;
	localparam logic [RULE_W-1:0] RULE_WEEKDAYS  = 4'd8;
	localparam logic [RULE_W-1:0] RULE_WEEKEND   = 4'd9;

	localparam logic [DAY_W-1:0] DAY_SUNDAY   = 3'd0;
	localparam logic [DAY_W-1:0] DAY_MONDAY   = 3'd1;
	localparam logic [DAY_W-1:0] DAY_FRIDAY   = 3'd5;
	localparam logic [DAY_W-1:0] DAY_SATURDAY = 3'd6;

	typedef struct packed {
		logic                action_on;
		logic [MINUTE_W-1:0] minute;
		logic [RULE_W-1:0]   rule;
		logic [LIGHT_W-1:0]  light;
	} entry_t;

	typedef struct packed {
		logic write_entry;
		logic load_tick;
		logic scan_rd;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic table_empty;
		logic scan_last;
	} dp_status_t;

	function automatic logic day_matches(input logic [RULE_W-1:0] rule,
			input logic [DAY_W-1:0] today);
		logic m;
		m = 1'b0;
		if (rule == RULE_EVERY_DAY)
			m = 1'b1;
		if (rule == {1'b0, today})
			m = 1'b1;
		if (rule == RULE_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY))
			m = 1'b1;
		if (rule == RULE_WEEKDAYS && today >= DAY_MONDAY && today <= DAY_FRIDAY)
			m = 1'b1;
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: src/tmt_ctrl.sv
// Sequencing state machine for schedule writes and tick scans.
`default_nettype none

module tmt_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tmt_pkg::OP_W-1:0]  opcode,
	input  wire tmt_pkg::dp_status_t       status,
	output tmt_pkg::dp_cmd_t               cmd,
	output logic                           busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		state_d         = state_q;
		cmd.write_entry = 1'b0;
		cmd.load_tick   = 1'b0;
		cmd.scan_rd     = 1'b0;
		cmd.flush       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == tmt_pkg::OP_SCHED_ON || opcode == tmt_pkg::OP_SCHED_OFF)
						cmd.write_entry = 1'b1;
					if (opcode == tmt_pkg::OP_TICK) begin
						cmd.load_tick = 1'b1;
						// An empty table yields nothing, so the tick ends here.
						if (!status.table_empty)
							state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |-> !cmd.scan_rd && !cmd.flush && !busy)
		else $error("schedule write outside idle");

	a_flush_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> $past(state_q) == ST_DRAIN)
		else $error("flush not preceded by drain");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

endmodule

`default_nettype wire

FILE: src/tmt_datapath.sv
// Event table memory, fill count, scan pipeline and result register.
`default_nettype none

module tmt_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tmt_pkg::dp_cmd_t              cmd,
	output tmt_pkg::dp_status_t                status,
	input  wire logic [tmt_pkg::OP_W-1:0]      opcode,
	input  wire logic [tmt_pkg::LIGHT_W-1:0]   light_number,
	input  wire logic [tmt_pkg::RULE_W-1:0]    day_rule,
	input  wire logic [tmt_pkg::MINUTE_W-1:0]  event_minute,
	input  wire logic [tmt_pkg::DAY_W-1:0]     current_day,
	input  wire logic [tmt_pkg::MINUTE_W-1:0]  current_minute,
	output logic                               strobe,
	output logic [tmt_pkg::LIGHT_W-1:0]        switch_light,
	output logic                               switch_on,
	output logic                               last_of_run
);

	tmt_pkg::entry_t mem [tmt_pkg::EVENT_SLOTS];

	logic [tmt_pkg::CNT_W-1:0]    count_q;
	logic [tmt_pkg::SLOT_W-1:0]   idx_q;
	logic [tmt_pkg::DAY_W-1:0]    day_q;
	logic [tmt_pkg::MINUTE_W-1:0] minute_q;
	tmt_pkg::entry_t              rd_data_s1;
	logic                         rd_valid_s1;
	logic                         pend_valid_q;
	logic [tmt_pkg::LIGHT_W-1:0]  pend_light_q;
	logic                         pend_on_q;
	logic                         strobe_q;
	logic [tmt_pkg::LIGHT_W-1:0]  light_q;
	logic                         on_q;
	logic                         last_q;
	logic                         table_full;
	logic                         do_write;
	logic                         match_s1;
	logic                         emit;
	tmt_pkg::entry_t              wr_entry;

	// Entries are never removed, so the valid slots are exactly those below the fill count.
	assign table_full = (count_q == tmt_pkg::CNT_W'(tmt_pkg::EVENT_SLOTS));
	assign do_write   = cmd.write_entry && !table_full;

	assign wr_entry.light     = light_number;
	assign wr_entry.rule      = day_rule;
	assign wr_entry.minute    = event_minute;
	assign wr_entry.action_on = (opcode == tmt_pkg::OP_SCHED_ON);

	assign status.table_empty = (count_q == '0);
	assign status.scan_last   = ((tmt_pkg::CNT_W'(idx_q) + tmt_pkg::CNT_W'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (do_write)
			mem[count_q[tmt_pkg::SLOT_W-1:0]] <= wr_entry;
		if (cmd.scan_rd)
			rd_data_s1 <= mem[idx_q];
		if (cmd.load_tick) begin
			day_q    <= current_day;
			minute_q <= current_minute;
		end
	end

	assign match_s1 = rd_valid_s1
		&& tmt_pkg::day_matches(rd_data_s1.rule, day_q)
		&& (rd_data_s1.minute == minute_q);

	// A match is held until the next match or flush so the final one can carry the last flag.
	assign emit = pend_valid_q && (match_s1 || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			if (do_write)
				count_q <= count_q + tmt_pkg::CNT_W'(1);
			if (cmd.load_tick)
				idx_q <= '0;
			else if (cmd.scan_rd)
				idx_q <= idx_q + tmt_pkg::SLOT_W'(1);
			rd_valid_s1 <= cmd.scan_rd;
			if (match_s1)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (match_s1) begin
			pend_light_q <= rd_data_s1.light;
			pend_on_q    <= rd_data_s1.action_on;
		end
		if (emit) begin
			light_q <= pend_light_q;
			on_q    <= pend_on_q;
			last_q  <= cmd.flush;
		end
	end

	assign strobe       = strobe_q;
	assign switch_light = light_q;
	assign switch_on    = on_q;
	assign last_of_run  = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tmt_pkg::CNT_W'(tmt_pkg::EVENT_SLOTS))
		else $error("fill count beyond table depth");

	a_flush_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> !rd_valid_s1)
		else $error("flush while a slot read is still in flight");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("result directly after the final result of a tick");

endmodule

`default_nettype wire

FILE: src/timed_event_match_table_unit.sv
// Top level of the timed event match table: controller and datapath.
//
//   channel   handshake         payload
//   input     start / busy      opcode, light_number, day_rule, event_minute,
//                               current_day, current_minute
//   result    strobe            switch_light, switch_on, last_of_run
//
// A schedule beat, or a tick beat over an empty table, ends in idle; busy stays low.
// Over a table holding N events, a tick keeps busy high after acceptance: scan does one
// memory read per slot, drain does the last compare, flush emits the final result.
// A read slot's result passes the pending and output registers, at most one per cycle.
// Reset empties the table at once through the fill count; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module timed_event_match_table_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [tmt_pkg::OP_W-1:0]      opcode,
	input  wire logic [tmt_pkg::LIGHT_W-1:0]   light_number,
	input  wire logic [tmt_pkg::RULE_W-1:0]    day_rule,
	input  wire logic [tmt_pkg::MINUTE_W-1:0]  event_minute,
	input  wire logic [tmt_pkg::DAY_W-1:0]     current_day,
	input  wire logic [tmt_pkg::MINUTE_W-1:0]  current_minute,
	output logic                               strobe,
	output logic [tmt_pkg::LIGHT_W-1:0]        switch_light,
	output logic                               switch_on,
	output logic                               last_of_run
);

	tmt_pkg::dp_cmd_t    cmd;
	tmt_pkg::dp_status_t status;

	tmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tmt_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.light_number   (light_number),
		.day_rule       (day_rule),
		.event_minute   (event_minute),
		.current_day    (current_day),
		.current_minute (current_minute),
		.strobe         (strobe),
		.switch_light   (switch_light),
		.switch_on      (switch_on),
		.last_of_run    (last_of_run)
	);

endmodule

`default_nettype wire
